@@ hw/rtl/huffman_code_bit_packer_defines.svh @@
// Assertion macros shared by the code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HCBP_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition implies another at the same clock edge.
`define HCBP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hcbp_pkg.sv @@
// Types and constants shared by the code bit packer modules.
`default_nettype none

package hcbp_pkg;

  localparam int unsigned ENTRY_W     = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned WORD_W      = ENTRY_W + BYTE_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_CODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_ENCODE = 2'd0,
    JOB_FLUSH  = 2'd1,
    JOB_ERROR  = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [SYM_W-1:0]   symbol;
    logic [ENTRY_W-1:0] code_bits;
    logic [LEN_W-1:0]   code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              status;
  } out_item_t;

  typedef struct packed {
    job_kind_e          kind;
    logic [ENTRY_W-1:0] code;
    logic [LEN_W-1:0]   len;
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/hcbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/hcbp_front.sv @@
// Front end: accepts items, keeps the code store and classifies each item into a job.
`default_nettype none

module hcbp_front #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hcbp_pkg::in_item_t in_item_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   push_o,
  output hcbp_pkg::job_t         job_o,
  input  wire logic              full_i
);

  import hcbp_pkg::*;

  localparam int unsigned AW      = $clog2(SYMBOL_COUNT);
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < ENTRY_W) ? MAX_CODE_LEN : ENTRY_W;
  localparam int unsigned STORE_W = ENTRY_W + LEN_W;

  logic                    accept;
  logic                    in_range;
  logic [AW-1:0]           idx;
  logic [LEN_W-1:0]        len_c;
  logic [ENTRY_W-1:0]      code_m;
  logic                    we;
  logic                    re;
  logic [STORE_W-1:0]      rdata;
  logic [SYMBOL_COUNT-1:0] vld_q;
  logic                    b_vld_q, b_vld_d;
  job_kind_e               b_kind_q, b_kind_d;
  logic                    b_hit_q, b_hit_d;
  logic [LEN_W-1:0]        rd_len;

  assign in_ready_o = !b_vld_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, in_item_i.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx        = in_item_i.symbol[AW-1:0];
  assign len_c      = (in_item_i.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                                : in_item_i.code_length;
  assign code_m     = in_item_i.code_bits & ~({ENTRY_W{1'b1}} << len_c);

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    b_vld_d  = b_vld_q && full_i;
    b_kind_d = b_kind_q;
    b_hit_d  = b_hit_q;
    if (accept) begin
      unique case (cmd_e'(in_item_i.cmd))
        CMD_LOAD: begin
          we = in_range;
        end
        CMD_ENCODE: begin
          re       = 1'b1;
          b_vld_d  = 1'b1;
          b_kind_d = JOB_ENCODE;
          b_hit_d  = in_range && vld_q[idx];
        end
        CMD_FLUSH: begin
          b_vld_d  = 1'b1;
          b_kind_d = JOB_FLUSH;
          b_hit_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      b_vld_q  <= 1'b0;
      b_kind_q <= JOB_ENCODE;
      b_hit_q  <= 1'b0;
    end else begin
      if (we) begin
        vld_q[idx] <= 1'b1;
      end
      b_vld_q  <= b_vld_d;
      b_kind_q <= b_kind_d;
      b_hit_q  <= b_hit_d;
    end
  end

  hcbp_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i ({len_c, code_m}),
    .re_i    (re),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  assign rd_len = rdata[ENTRY_W +: LEN_W];
  assign push_o = b_vld_q && !full_i;

  always_comb begin
    job_o.kind = b_kind_q;
    job_o.code = rdata[ENTRY_W-1:0];
    job_o.len  = rd_len;
    if (b_kind_q == JOB_ENCODE && (!b_hit_q || rd_len == '0)) begin
      job_o.kind = JOB_ERROR;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hcbp_queue.sv @@
// Short job queue between the front end and the bit packing back end.
`default_nettype none

module hcbp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hcbp_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output hcbp_pkg::job_t      job_o,
  output logic                empty_o
);

  import hcbp_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hcbp_back.sv @@
// Back end: appends codes to the pending bit word and emits whole bytes, one per cycle while not stalled.
`default_nettype none

module hcbp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hcbp_pkg::job_t job_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output hcbp_pkg::out_item_t out_item_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);

  import hcbp_pkg::*;

  localparam logic [LEN_W-1:0] BYTE_N  = LEN_W'(BYTE_W);
  localparam logic [LEN_W-1:0] TWO_N   = LEN_W'(2 * BYTE_W);
  localparam logic [LEN_W-1:0] WORD_N  = LEN_W'(WORD_W);

  logic [WORD_W-1:0] word_q, word_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         item_q, item_d;
  logic              slot;
  logic [LEN_W-1:0]  sh;
  logic [LEN_W-1:0]  total;
  logic [WORD_W-1:0] merged;

  assign slot   = !out_valid_q || out_ready_i;
  assign sh     = WORD_N - rem_q - job_i.len;
  assign total  = rem_q + job_i.len;
  assign merged = word_q | (WORD_W'(job_i.code) << sh);

  always_comb begin
    word_d      = word_q;
    rem_d       = rem_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    item_d      = item_q;
    if (slot) begin
      if (rem_q >= BYTE_N) begin
        out_valid_d     = 1'b1;
        item_d.out_byte = word_q[WORD_W-1 -: BYTE_W];
        item_d.last     = rem_q < TWO_N;
        item_d.status   = STATUS_OK;
        word_d          = word_q << BYTE_W;
        rem_d           = rem_q - BYTE_N;
      end else if (!empty_i) begin
        pop_o = 1'b1;
        unique case (job_i.kind)
          JOB_ENCODE: begin
            word_d = merged;
            rem_d  = total;
            if (total >= BYTE_N) begin
              out_valid_d     = 1'b1;
              item_d.out_byte = merged[WORD_W-1 -: BYTE_W];
              item_d.last     = total < TWO_N;
              item_d.status   = STATUS_OK;
              word_d          = merged << BYTE_W;
              rem_d           = total - BYTE_N;
            end
          end
          JOB_FLUSH: begin
            if (rem_q != '0) begin
              out_valid_d     = 1'b1;
              item_d.out_byte = word_q[WORD_W-1 -: BYTE_W];
              item_d.last     = 1'b1;
              item_d.status   = STATUS_OK;
            end
            word_d = '0;
            rem_d  = '0;
          end
          JOB_ERROR: begin
            out_valid_d     = 1'b1;
            item_d.out_byte = '0;
            item_d.last     = 1'b1;
            item_d.status   = STATUS_NO_CODE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_item_o  = item_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/huffman_code_bit_packer.sv @@
// Top level of the variable-length code bit packer.
//
// Input items arrive on in_item_i with in_valid_i/in_ready_o. A load item writes one
// symbol's code and length into the code store, an encode item appends the symbol's code
// to the pending bits, and a flush item emits the last 1 to 7 bits zero-padded.
// Result items leave on out_item_o with out_valid_o/out_ready_i, one byte per item,
// first bit in the most significant position; last marks the final byte of an input item.
// The front end takes one item per cycle while the queue has room, and passes encode,
// flush and error jobs through a two-entry queue to the back end, which emits one byte
// per cycle from the pending word while the receiver accepts them. An encode job yields
// up to four bytes, flush and error jobs at most one; loads never reach the back end.
// An item's first result passes the job register, a queue entry and the output register.
// Reset clears the pending bits and marks every code store entry as having no code; no
// clearing pass is needed. When the receiver stalls the output register holds its item,
// the queue fills, and in_ready_o falls once the front end cannot hand on its job.
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hcbp_pkg::in_item_t in_item_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output hcbp_pkg::out_item_t     out_item_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i
);

  import hcbp_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .push_o     (q_push),
    .job_o      (push_job),
    .full_i     (q_full)
  );

  hcbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (pop_job),
    .empty_o (q_empty)
  );

  hcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  `HCBP_ASSERT_ALWAYS(a_queue_no_overflow, !(q_push && q_full), "Job pushed into a full queue.")
  `HCBP_ASSERT_ALWAYS(a_queue_no_underflow, !(q_pop && q_empty), "Job popped from an empty queue.")
  `HCBP_ASSERT_IMPLY(a_error_item_shape, out_valid_o && out_item_o.status == STATUS_NO_CODE, out_item_o.last && out_item_o.out_byte == '0, "Error item is not a final zero byte.")

endmodule

`default_nettype wire

@@ test/huffman_code_bit_packer_checker.sv @@
// Checker for the code bit packer: predicts the output bytes of each accepted item and compares them.
`timescale 1ns / 1ps

module huffman_code_bit_packer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbp_pkg::in_item_t  in_item_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  hcbp_pkg::out_item_t out_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  output int                  fails_o,
  output int                  bytes_due_o
);

  import hcbp_pkg::*;

  logic [ENTRY_W-1:0] code_tab [256];
  logic [LEN_W-1:0]   len_tab  [256];
  logic [6:0]         held_bits;
  logic [2:0]         held_count;
  out_item_t          due_bytes [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails_o++;
  endtask

  task automatic pack_item(input in_item_t it);
    logic [LEN_W-1:0] len;
    logic [63:0]      acc;
    int unsigned      total;
    out_item_t        r;
    case (it.cmd)
      CMD_LOAD: begin
        code_tab[it.symbol] = it.code_bits;
        len_tab[it.symbol]  = (it.code_length > ENTRY_W) ? LEN_W'(ENTRY_W) : it.code_length;
      end
      CMD_ENCODE: begin
        len = len_tab[it.symbol];
        if (len == '0) begin
          r.out_byte = '0;
          r.last     = 1'b1;
          r.status   = STATUS_NO_CODE;
          due_bytes.push_back(r);
        end else begin
          acc   = ({57'd0, held_bits} << len) |
                  ({32'd0, code_tab[it.symbol]} & ((64'd1 << len) - 64'd1));
          total = held_count + len;
          while (total >= 8) begin
            r.out_byte = acc[total-8 +: 8];
            r.last     = (total < 16);
            r.status   = STATUS_OK;
            due_bytes.push_back(r);
            total -= 8;
          end
          held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
          held_count = 3'(total);
        end
      end
      CMD_FLUSH: begin
        if (held_count != '0) begin
          r.out_byte = {1'b0, held_bits} << (8 - held_count);
          r.last     = 1'b1;
          r.status   = STATUS_OK;
          due_bytes.push_back(r);
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (due_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected item, byte %02h", got.out_byte));
      return;
    end
    want = due_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        code_tab[i] = '0;
        len_tab[i]  = '0;
      end
      held_bits   = '0;
      held_count  = '0;
      due_bytes.delete();
      fails_o     = 0;
      bytes_due_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_byte(out_item_i);
      if (in_valid_i && in_ready_i) pack_item(in_item_i);
      bytes_due_o = due_bytes.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the code bit packer: drives load, encode, flush and unknown items and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import hcbp_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic      clk;
  logic      rst_n;
  in_item_t  in_item;
  logic      in_valid;
  logic      in_ready;
  out_item_t out_item;
  logic      out_valid;
  logic      out_ready;
  int        fails;
  int        bytes_due;
  int        send_idle;
  int        recv_stall;
  logic [7:0] coded_syms [$];

  huffman_code_bit_packer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_item_i  (in_item),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_item_o (out_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready)
  );

  huffman_code_bit_packer_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_item_i  (in_item),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .out_item_i (out_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .fails_o    (fails),
    .bytes_due_o(bytes_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] sym,
                                         logic [31:0] code, logic [5:0] len);
    in_item_t it;
    it.cmd         = cmd;
    it.symbol      = sym;
    it.code_bits   = code;
    it.code_length = len;
    return it;
  endfunction

  task automatic drive_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random();
    in_item_t it;
    int       pick;
    pick           = $urandom_range(0, 99);
    it.symbol      = 8'($urandom);
    it.code_bits   = $urandom;
    it.code_length = 6'($urandom_range(1, 32));
    if (pick < 15) begin
      it.cmd = CMD_LOAD;
      if ($urandom_range(0, 9) == 0) it.code_length = 6'($urandom_range(0, 63));
      if (it.code_length != '0) coded_syms.push_back(it.symbol);
    end else if (pick < 85) begin
      it.cmd = CMD_ENCODE;
      if ($urandom_range(0, 9) != 0)
        it.symbol = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
    end else if (pick < 97) begin
      it.cmd = CMD_FLUSH;
    end else begin
      it.cmd = CMD_UNKNOWN;
    end
    drive_item(it);
  endtask

  initial begin
    #2_000_000;
    $display("FAIL huffman_code_bit_packer");
    $finish;
  end

  initial begin
    send_idle  = 0;
    recv_stall = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: empty table, empty flush, extreme codes, saturation and errors.
    drive_item(make_item(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    drive_item(make_item(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
    drive_item(make_item(CMD_LOAD, 8'h00, 32'h0000_0000, 6'd1));
    drive_item(make_item(CMD_LOAD, 8'hA5, 32'h8000_0001, 6'd63));
    drive_item(make_item(CMD_LOAD, 8'h3C, 32'hFFFF_FF55, 6'd7));
    drive_item(make_item(CMD_LOAD, 8'h5A, 32'hDEAD_BEEF, 6'd0));
    drive_item(make_item(CMD_LOAD, 8'h81, 32'h0000_0002, 6'd2));
    drive_item(make_item(CMD_LOAD, 8'h42, 32'h1234_5678, 6'd33));
    drive_item(make_item(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63));
    drive_item(make_item(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h5A, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h81, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    drive_item(make_item(CMD_ENCODE, 8'h3C, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'hA5, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h42, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_ENCODE, 8'h3C, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0));
    drive_item(make_item(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0));
    coded_syms = '{8'hFF, 8'h00, 8'hA5, 8'h3C, 8'h81, 8'h42};

    repeat (31) send_random();
    send_idle = 77;
    repeat (31) send_random();
    send_idle  = 0;
    recv_stall = 77;
    repeat (31) send_random();
    send_idle  = 18;
    recv_stall = 18;
    repeat (31) send_random();

    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && bytes_due == 0) begin
      $display("PASS huffman_code_bit_packer");
    end else begin
      $display("FAIL huffman_code_bit_packer");
    end
    $finish;
  end

endmodule
